### hdl/assert_macros.svh
// Assertion macros shared by the servo mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sapm_pkg.sv
// Package with shared widths, codes, reset values and control structs for the servo mapper.
`timescale 1ns / 1ps

package sapm_pkg;

    localparam int JOINT_COUNT = 3;

    localparam int MODE_W      = 2;
    localparam int JOINT_W     = 2;
    localparam int ANGLE_W     = 17;
    localparam int REQ_W       = 16;
    localparam int ANGLE_LIM_W = 9;
    localparam int PULSE_W     = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    // Stream packing
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    // Divider: |product| >> 8 fits 23 bits, divisor (angle span) fits 9 bits
    localparam int QUO_W     = 23;
    localparam int REM_W     = 9;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = 5;

    // Reset values of the configuration registers
    localparam logic signed [ANGLE_LIM_W-1:0] ANGLE_LO_RST = -9'sd90;
    localparam logic signed [ANGLE_LIM_W-1:0] ANGLE_HI_RST = 9'sd90;
    localparam logic [PULSE_W-1:0]            PULSE_LO_RST = 15'd500;
    localparam logic [PULSE_W-1:0]            PULSE_HI_RST = 15'd2500;
    localparam logic [PULSE_W-1:0]            NEUTRAL_RST  = 15'd1500;

    typedef enum logic [MODE_W-1:0] {
        MODE_ANGLE = 2'd0,
        MODE_RAW   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_BAD   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_LO = 3'd0,
        REG_ANGLE_HI = 3'd1,
        REG_PULSE_LO = 3'd2,
        REG_PULSE_HI = 3'd3,
        REG_NEUTRAL0 = 3'd4,
        REG_NEUTRAL1 = 3'd5,
        REG_NEUTRAL2 = 3'd6,
        REG_INVERT   = 3'd7
    } cfg_index_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div_init;
        logic div_step;
        logic finish;
    } sapm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_arith;
    } sapm_status_t;

endpackage

### hdl/sapm_ctrl.sv
// Controller state machine: sequences load, multiply, divide and result hand-off.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sapm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sapm_pkg::sapm_status_t status,
    output sapm_pkg::sapm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_FIN
    } state_t;

    localparam logic [sapm_pkg::CNT_W-1:0] CNT_LAST =
        sapm_pkg::CNT_W'(sapm_pkg::DIV_STEPS - 1);

    state_t                       state_reg, state_next;
    logic [sapm_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Commands decoded from state
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.mul      = (state_reg == ST_MUL);
        cmd.div_init = (state_reg == ST_DINIT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.finish   = (state_reg == ST_FIN) && out_free;
    end

    // Next state, step counter and output valid
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.need_arith ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "input still ready the cycle after a transfer")
    `ASSERT_NEXT(a_div_ends, (state_reg == ST_DIV) && (cnt_reg == CNT_LAST),
        state_reg == ST_FIN, "divider did not stop after its last step")
    `ASSERT_NEXT(a_fin_waits, (state_reg == ST_FIN) && out_valid_reg && !out_ready,
        (state_reg == ST_FIN) && out_valid_reg, "result dropped while output stalled")

endmodule

### hdl/sapm_datapath.sv
// Datapath: configuration registers, override flags, clamps, multiplier and serial divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sapm_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration writes
    input  logic                                   cfg_we,
    input  logic [sapm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sapm_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input item fields
    input  logic [sapm_pkg::MODE_W-1:0]            in_mode,
    input  logic [sapm_pkg::JOINT_W-1:0]           in_joint,
    input  logic signed [sapm_pkg::ANGLE_W-1:0]    in_angle,
    input  logic [sapm_pkg::REQ_W-1:0]             in_pulse_request,
    // control
    input  sapm_pkg::sapm_cmd_t                    cmd,
    output sapm_pkg::sapm_status_t                 status,
    // result fields
    output logic [sapm_pkg::JOINT_W-1:0]           joint_out,
    output logic [sapm_pkg::PULSE_W-1:0]           pulse_width,
    output logic                                   level_written,
    output logic                                   limit_hit,
    output logic                                   rejected
);

    localparam int AW   = sapm_pkg::ANGLE_W + 1;     // angle after negation
    localparam int SPW  = sapm_pkg::ANGLE_LIM_W + 1; // signed span
    localparam int DW   = sapm_pkg::PULSE_W + 1;     // signed pulse difference
    localparam int PW   = sapm_pkg::ANGLE_W + DW;    // product
    localparam int SUMW = sapm_pkg::QUO_W + 2;       // neutral plus delta
    localparam int JEXT = 1 << sapm_pkg::JOINT_W;

    // Configuration registers
    logic signed [sapm_pkg::ANGLE_LIM_W-1:0] angle_lo_reg, angle_hi_reg;
    logic [sapm_pkg::PULSE_W-1:0]            pulse_lo_reg, pulse_hi_reg;
    logic [sapm_pkg::PULSE_W-1:0]            neutral_reg [sapm_pkg::JOINT_COUNT];
    logic [sapm_pkg::JOINT_COUNT-1:0]        invert_reg;
    logic [sapm_pkg::JOINT_COUNT-1:0]        flags_reg;

    // Per-item working registers
    logic [sapm_pkg::JOINT_W-1:0]            joint_reg;
    logic                                    rej_reg, written_reg, clamp_reg, is_angle_reg;
    logic [sapm_pkg::PULSE_W-1:0]            pw_reg;
    logic signed [sapm_pkg::ANGLE_W-1:0]     c_reg;
    logic signed [DW-1:0]                    diff_reg;
    logic [sapm_pkg::REM_W-1:0]              span_reg;
    logic signed [PW-1:0]                    prod_reg;
    logic [sapm_pkg::QUO_W-1:0]              quo_reg;
    logic [sapm_pkg::REM_W-1:0]              rem_reg;
    logic                                    neg_reg;

    // Output registers
    logic [sapm_pkg::JOINT_W-1:0]            joint_out_reg;
    logic [sapm_pkg::PULSE_W-1:0]            pw_out_reg;
    logic                                    written_out_reg, clamp_out_reg, rej_out_reg;

    // Load-time decode
    sapm_pkg::mode_t                         mode;
    logic [JEXT-1:0]                         inv_ext, flags_ext;
    logic                                    joint_ok, ovr;
    logic signed [AW-1:0]                    a_src, a_val, lo_q, hi_q, c_val;
    logic signed [SPW-1:0]                   span;
    logic                                    span_pos;
    logic [sapm_pkg::REQ_W:0]                req_x, plo_x, phi_x, raw_p1, raw_p2;

    // Multiply, divide and final clamp
    logic signed [PW-1:0]                    prod_full, prod_mag;
    logic [sapm_pkg::REM_W:0]                rem_shift;
    logic                                    rem_ge;
    logic signed [SUMW-1:0]                  delta, sum, plo_s, phi_s, p1, p2;

    assign mode      = sapm_pkg::mode_t'(in_mode);
    assign inv_ext   = JEXT'(invert_reg);
    assign flags_ext = JEXT'(flags_reg);
    assign joint_ok  = (int'(in_joint) < sapm_pkg::JOINT_COUNT);
    assign ovr       = flags_ext[in_joint];

    // Angle: optional negation, then clamp to the limits scaled into Q8.8 (sign-extended)
    assign a_src = AW'(in_angle);
    assign a_val = inv_ext[in_joint] ? -a_src : a_src;
    assign lo_q  = {angle_lo_reg[sapm_pkg::ANGLE_LIM_W-1], angle_lo_reg, 8'b0};
    assign hi_q  = {angle_hi_reg[sapm_pkg::ANGLE_LIM_W-1], angle_hi_reg, 8'b0};
    always_comb
    begin
        if (a_val < lo_q)
        begin
            c_val = lo_q;
        end
        else if (a_val > hi_q)
        begin
            c_val = hi_q;
        end
        else
        begin
            c_val = a_val;
        end
    end

    assign span     = SPW'(angle_hi_reg) - SPW'(angle_lo_reg);
    assign span_pos = !span[SPW-1] && (span != '0);

    // Raw pulse clamp: low bound first, then high bound
    assign req_x  = {1'b0, in_pulse_request};
    assign plo_x  = (sapm_pkg::REQ_W + 1)'(pulse_lo_reg);
    assign phi_x  = (sapm_pkg::REQ_W + 1)'(pulse_hi_reg);
    assign raw_p1 = (req_x < plo_x) ? plo_x : req_x;
    assign raw_p2 = (raw_p1 > phi_x) ? phi_x : raw_p1;

    assign status.need_arith = joint_ok && (mode == sapm_pkg::MODE_ANGLE) && !ovr && span_pos;

    // Product, magnitude and one restoring divide step
    assign prod_full = c_reg * diff_reg;
    assign prod_mag  = prod_reg[PW-1] ? -prod_reg : prod_reg;
    assign rem_shift = {rem_reg, quo_reg[sapm_pkg::QUO_W-1]};
    assign rem_ge    = (rem_shift >= (sapm_pkg::REM_W + 1)'(span_reg));

    // Neutral plus signed delta, then pulse clamp
    assign delta = neg_reg ? -SUMW'(quo_reg) : SUMW'(quo_reg);
    assign sum   = SUMW'(neutral_reg[joint_reg]) + delta;
    assign plo_s = SUMW'(pulse_lo_reg);
    assign phi_s = SUMW'(pulse_hi_reg);
    assign p1    = (sum < plo_s) ? plo_s : sum;
    assign p2    = (p1 > phi_s) ? phi_s : p1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_lo_reg <= sapm_pkg::ANGLE_LO_RST;
            angle_hi_reg <= sapm_pkg::ANGLE_HI_RST;
            pulse_lo_reg <= sapm_pkg::PULSE_LO_RST;
            pulse_hi_reg <= sapm_pkg::PULSE_HI_RST;
            for (int j = 0; j < sapm_pkg::JOINT_COUNT; j++)
            begin
                neutral_reg[j] <= sapm_pkg::NEUTRAL_RST;
            end
            invert_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (sapm_pkg::cfg_index_t'(cfg_index))
                sapm_pkg::REG_ANGLE_LO: angle_lo_reg <= cfg_data[sapm_pkg::ANGLE_LIM_W-1:0];
                sapm_pkg::REG_ANGLE_HI: angle_hi_reg <= cfg_data[sapm_pkg::ANGLE_LIM_W-1:0];
                sapm_pkg::REG_PULSE_LO: pulse_lo_reg <= cfg_data[sapm_pkg::PULSE_W-1:0];
                sapm_pkg::REG_PULSE_HI: pulse_hi_reg <= cfg_data[sapm_pkg::PULSE_W-1:0];
                sapm_pkg::REG_NEUTRAL0: neutral_reg[0] <= cfg_data[sapm_pkg::PULSE_W-1:0];
                sapm_pkg::REG_NEUTRAL1: neutral_reg[1] <= cfg_data[sapm_pkg::PULSE_W-1:0];
                sapm_pkg::REG_NEUTRAL2: neutral_reg[2] <= cfg_data[sapm_pkg::PULSE_W-1:0];
                sapm_pkg::REG_INVERT:   invert_reg <= cfg_data[sapm_pkg::JOINT_COUNT-1:0];
                default:                invert_reg <= invert_reg;
            endcase
        end
    end

    // Override flags: set by a raw pulse, cleared by a clear command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (cmd.load && joint_ok)
        begin
            for (int j = 0; j < sapm_pkg::JOINT_COUNT; j++)
            begin
                if (in_joint == sapm_pkg::JOINT_W'(j))
                begin
                    if (mode == sapm_pkg::MODE_RAW)
                    begin
                        flags_reg[j] <= 1'b1;
                    end
                    else if (mode == sapm_pkg::MODE_CLEAR)
                    begin
                        flags_reg[j] <= 1'b0;
                    end
                end
            end
        end
    end

    // Item capture, multiply and divide
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            joint_reg    <= in_joint;
            rej_reg      <= 1'b0;
            written_reg  <= 1'b0;
            clamp_reg    <= 1'b0;
            is_angle_reg <= 1'b0;
            pw_reg       <= '0;
            c_reg        <= c_val[sapm_pkg::ANGLE_W-1:0];
            diff_reg     <= DW'(pulse_hi_reg) - DW'(pulse_lo_reg);
            span_reg     <= span[sapm_pkg::REM_W-1:0];
            quo_reg      <= '0;
            neg_reg      <= 1'b0;
            if (!joint_ok || (mode == sapm_pkg::MODE_BAD))
            begin
                rej_reg <= 1'b1;
            end
            else if (mode == sapm_pkg::MODE_ANGLE)
            begin
                if (ovr)
                begin
                    rej_reg <= 1'b1;
                end
                else
                begin
                    is_angle_reg <= 1'b1;
                    written_reg  <= 1'b1;
                    clamp_reg    <= (c_val != a_val);
                end
            end
            else if (mode == sapm_pkg::MODE_RAW)
            begin
                written_reg <= 1'b1;
                pw_reg      <= raw_p2[sapm_pkg::PULSE_W-1:0];
                clamp_reg   <= (raw_p2 != req_x);
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full;
        end
        if (cmd.div_init)
        begin
            quo_reg <= prod_mag[sapm_pkg::QUO_W+7:8];
            neg_reg <= prod_reg[PW-1];
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[sapm_pkg::QUO_W-2:0], rem_ge};
            rem_reg <= rem_ge ? sapm_pkg::REM_W'(rem_shift - (sapm_pkg::REM_W + 1)'(span_reg))
                              : rem_shift[sapm_pkg::REM_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_out_reg   <= '0;
            pw_out_reg      <= '0;
            written_out_reg <= 1'b0;
            clamp_out_reg   <= 1'b0;
            rej_out_reg     <= 1'b0;
        end
        else if (cmd.finish)
        begin
            joint_out_reg   <= joint_reg;
            pw_out_reg      <= is_angle_reg ? p2[sapm_pkg::PULSE_W-1:0] : pw_reg;
            written_out_reg <= written_reg;
            clamp_out_reg   <= clamp_reg;
            rej_out_reg     <= rej_reg;
        end
    end

    assign joint_out     = joint_out_reg;
    assign pulse_width   = pw_out_reg;
    assign level_written = written_out_reg;
    assign limit_hit     = clamp_out_reg;
    assign rejected      = rej_out_reg;

    // Checks
    `ASSERT_IMPL(a_rej_no_write, rej_out_reg, !written_out_reg && !clamp_out_reg,
        "rejected result carries a write or clamp flag")
    `ASSERT_IMPL(a_no_write_zero, !written_out_reg, pw_out_reg == '0,
        "nonzero pulse width without a level write")
    `ASSERT_IMPL(a_clamp_written, clamp_out_reg, written_out_reg,
        "clamp flag without a level write")

endmodule

### hdl/servo_angle_to_pulse_mapper_core.sv
// Top level of the servo angle-to-pulse mapper: stream ports, config port, controller and datapath.
// An angle command on a valid, non-overridden joint with a positive angle span passes through
// multiply, the 23-step serial divider and clamp before m_axis_tvalid rises; every other command
// goes straight to the result state. A new command is taken only once the previous one has left
// the result state, which holds while an earlier result waits unaccepted. A finished result waits
// in the output register while the next command is taken. Reset (rst_n low, asynchronous)
// restores register defaults and clears all override flags; no clearing pass follows.
`timescale 1ns / 1ps

module servo_angle_to_pulse_mapper_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // command stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [1:0] joint, [18:2] angle, [34:19] pulse_request, [39:35] zero
    input  logic [sapm_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] mode
    input  logic [sapm_pkg::S_TUSER_W-1:0]       s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [1:0] joint_out, [16:2] pulse_width, [23:17] zero
    output logic [sapm_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // [0] level_written, [1] limit_hit, [2] rejected
    output logic [sapm_pkg::M_TUSER_W-1:0]       m_axis_tuser,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sapm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sapm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int ANG_LSB = sapm_pkg::JOINT_W;
    localparam int REQ_LSB = ANG_LSB + sapm_pkg::ANGLE_W;
    localparam int OUT_PAD = sapm_pkg::M_TDATA_W - sapm_pkg::JOINT_W - sapm_pkg::PULSE_W;

    sapm_pkg::sapm_cmd_t                  cmd;
    sapm_pkg::sapm_status_t               status;
    logic [sapm_pkg::JOINT_W-1:0]         joint_out;
    logic [sapm_pkg::PULSE_W-1:0]         pulse_width;
    logic                                 level_written, limit_hit, rejected;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    sapm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    sapm_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_mode          (s_axis_tuser[sapm_pkg::MODE_W-1:0]),
        .in_joint         (s_axis_tdata[sapm_pkg::JOINT_W-1:0]),
        .in_angle         (s_axis_tdata[REQ_LSB-1:ANG_LSB]),
        .in_pulse_request (s_axis_tdata[REQ_LSB+sapm_pkg::REQ_W-1:REQ_LSB]),
        .cmd              (cmd),
        .status           (status),
        .joint_out        (joint_out),
        .pulse_width      (pulse_width),
        .level_written    (level_written),
        .limit_hit        (limit_hit),
        .rejected         (rejected)
    );

    // Result packing
    assign m_axis_tdata = {{OUT_PAD{1'b0}}, pulse_width, joint_out};
    assign m_axis_tuser = {rejected, limit_hit, level_written};

endmodule
